>>> rtl/core/srwi_pkg.sv
`default_nettype none

package srwi_pkg;

  localparam int RING_DEPTH_DEFAULT = 256;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 10;
  localparam int PAY_W    = 64;
  localparam int BASE_W   = 8;
  localparam int RIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;
  localparam int WCNT_W   = 9;
  localparam int ENTRY_W  = KEY_W + PAY_W;

  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  new_key;
    logic [PAY_W-1:0]  new_payload;
    logic [BASE_W-1:0] start_base;
    logic [RIDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [WCNT_W-1:0]   window_count;
    logic [KEY_W-1:0]    read_key;
    logic [PAY_W-1:0]    read_payload;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/sorted_ring_window_insert_top.sv
// Start: subtracts RING_DEPTH from the base position until it lies below RING_DEPTH.
// Read: an index outside the window skips the store read. Insert: each entry searched is
// read, then compared, and each entry moved through the single entry store is read, then written.
// One beat is worked on at a time; a finished result waits in the output register.
// Reset clears the control state, base and count; the store contents stay undefined.
`default_nettype none

module sorted_ring_window_insert_top #(
  parameter int RING_DEPTH = srwi_pkg::RING_DEPTH_DEFAULT
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire srwi_pkg::in_t   in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output srwi_pkg::out_t       out_o
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int BW = (PW > srwi_pkg::BASE_W) ? PW : srwi_pkg::BASE_W;
  localparam int RW = (CW > srwi_pkg::RIDX_W) ? CW : srwi_pkg::RIDX_W;
  localparam logic [PW-1:0] LAST_PLACE = PW'(RING_DEPTH - 1);
  localparam logic [CW:0]   DEPTH_S    = (CW + 1)'(RING_DEPTH);
  localparam logic [BW:0]   DEPTH_B    = (BW + 1)'(RING_DEPTH);
  localparam logic [CW-1:0] DEPTH_C    = CW'(RING_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_BASE     = 8'b0000_0010,
    S_SRCH_RD  = 8'b0000_0100,
    S_SRCH_CMP = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_READ     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0] base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [BW-1:0] bw_q, bw_d;
  logic [srwi_pkg::KEY_W-1:0] key_q, key_d;
  logic [srwi_pkg::PAY_W-1:0] pay_q, pay_d;
  srwi_pkg::out_t res_q, res_d;
  srwi_pkg::out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic                          ram_we;
  logic [PW-1:0]                 ram_waddr;
  srwi_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [PW-1:0]                 ram_raddr;
  srwi_pkg::entry_t              ram_rdata;

  logic [CW-1:0] place_off;
  logic [CW:0]   place_sum;
  logic [PW-1:0] place_w;
  logic [PW-1:0] ptr_inc;
  logic [PW-1:0] ptr_dec;
  logic          is_full;
  logic          read_in_range;
  logic          out_free;

  // Shared wrap adder: maps a window offset to a store place.
  assign place_off = (state_q == S_IDLE) ? CW'(in_i.read_index) : count_q;
  assign place_sum = {1'b0, CW'(base_q)} + {1'b0, place_off};
  always_comb begin
    if (place_sum >= DEPTH_S) begin
      place_w = PW'(place_sum - DEPTH_S);
    end else begin
      place_w = PW'(place_sum);
    end
  end

  assign ptr_inc       = (ptr_q == LAST_PLACE) ? '0 : ptr_q + PW'(1);
  assign ptr_dec       = (ptr_q == '0) ? LAST_PLACE : ptr_q - PW'(1);
  assign is_full       = (count_q == DEPTH_C);
  assign read_in_range = (RW'(in_i.read_index) < RW'(count_q));
  assign out_free      = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    bw_d        = bw_q;
    key_d       = key_q;
    pay_d       = pay_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = '{key: key_q, payload: pay_q};
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d = in_i.new_key;
          pay_d = in_i.new_payload;
          res_d = '0;
          case (in_i.func)
            srwi_pkg::FUNC_START: begin
              bw_d    = BW'(in_i.start_base);
              state_d = S_BASE;
            end
            srwi_pkg::FUNC_INSERT: begin
              idx_d   = '0;
              ptr_d   = base_q;
              state_d = S_SRCH_RD;
            end
            default: begin
              res_d.slot_index = in_i.read_index;
              if (read_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = place_w;
                state_d   = S_READ;
              end else begin
                res_d.status = srwi_pkg::ST_RANGE;
                state_d      = S_DONE;
              end
            end
          endcase
        end
      end
      S_BASE: begin
        if ({1'b0, bw_q} >= DEPTH_B) begin
          bw_d = BW'({1'b0, bw_q} - DEPTH_B);
        end else begin
          base_d       = PW'(bw_q);
          count_d      = '0;
          res_d.status = srwi_pkg::ST_OK;
          state_d      = S_DONE;
        end
      end
      S_SRCH_RD: begin
        if (idx_q == count_q) begin
          if (is_full) begin
            res_d.status = srwi_pkg::ST_FULL;
            state_d      = S_DONE;
          end else begin
            pos_d   = idx_q;
            idx_d   = count_q;
            ptr_d   = place_w;
            state_d = S_SHIFT_RD;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (ram_rdata.key == key_q) begin
          ram_we           = 1'b1;
          res_d.status     = srwi_pkg::ST_REPLACED;
          res_d.slot_index = srwi_pkg::SLOT_W'(idx_q);
          state_d          = S_DONE;
        end else if (ram_rdata.key > key_q) begin
          if (is_full) begin
            res_d.status = srwi_pkg::ST_FULL;
            state_d      = S_DONE;
          end else begin
            pos_d   = idx_q;
            idx_d   = count_q;
            ptr_d   = place_w;
            state_d = S_SHIFT_RD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          ptr_d   = ptr_inc;
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (idx_q == pos_q) begin
          ram_we           = 1'b1;
          count_d          = count_q + CW'(1);
          res_d.status     = srwi_pkg::ST_INSERTED;
          res_d.slot_index = srwi_pkg::SLOT_W'(pos_q);
          state_d          = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_dec;
          state_d   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_dec;
        idx_d     = idx_q - CW'(1);
        state_d   = S_SHIFT_RD;
      end
      S_READ: begin
        res_d.status       = srwi_pkg::ST_OK;
        res_d.read_key     = ram_rdata.key;
        res_d.read_payload = ram_rdata.payload;
        state_d            = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_d              = res_q;
          out_d.window_count = srwi_pkg::WCNT_W'(count_q);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    ptr_q <= ptr_d;
    bw_q  <= bw_d;
    key_q <= key_d;
    pay_q <= pay_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  srwi_ram #(
    .Width(srwi_pkg::ENTRY_W),
    .Depth(RING_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("window count exceeds the store depth");

  a_base_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, base_q} < DEPTH_S[PW:0])
    else $error("window base outside the store");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
    else $error("store written outside an active operation");

  a_shift_above_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_WR) |-> (idx_q > pos_q))
    else $error("shift moved an entry below the insert position");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD && idx_q == pos_q) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the window by one");
`endif

endmodule

`default_nettype wire

>>> rtl/core/srwi_ram.sv
`default_nettype none

module srwi_ram #(
  parameter int Width = srwi_pkg::ENTRY_W,
  parameter int Depth = srwi_pkg::RING_DEPTH_DEFAULT,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
